// ===== sv/tfdp_pkg.sv =====
// Package: shared widths, coefficient tables, register indexes and queue types.
`default_nettype none
package tfdp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int COEF_W   = 16;
  localparam int ACC_W    = 34;
  localparam int TAPS     = 5;
  localparam int SCALE_SH = 15;
  localparam int DEPTH_W  = 5;
  localparam int DEPTH_MIN = 8;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DEPTH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TYPE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DEPTH = 1'd1;

  localparam logic               FILTER_TYPE_RST  = 1'b1;
  localparam logic [DEPTH_W-1:0] SAMPLE_DEPTH_RST = 5'd8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Q15 coefficients indexed [filter_type][tap]; unused taps are zero.
  localparam coef_t LF_COEF [2][TAPS] = '{
    '{16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd852, 16'sd17236, 16'sd17236, -16'sd852, 16'sd0}
  };
  localparam coef_t HF_COEF [2][TAPS] = '{
    '{-16'sd2048, 16'sd4096, -16'sd2048, 16'sd0, 16'sd0},
    '{16'sd1016, -16'sd3801, 16'sd5570, -16'sd3801, 16'sd1016}
  };

  typedef struct packed {
    logic mode;
    acc_t sum;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== sv/tfdp_if.sv =====
// Stream interfaces for the input sample channel and the pixel result channel.
`default_nettype none
interface tfdp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] cur_tap_0;
  logic [15:0] cur_tap_1;
  logic [15:0] cur_tap_2;
  logic [15:0] cur_tap_3;
  logic [15:0] cur_tap_4;
  logic [15:0] adj_tap_0;
  logic [15:0] adj_tap_1;
  logic [15:0] adj_tap_2;
  logic [15:0] adj_tap_3;
  logic [15:0] adj_tap_4;

  modport source(output valid, mode, cur_tap_0, cur_tap_1, cur_tap_2, cur_tap_3, cur_tap_4,
                 adj_tap_0, adj_tap_1, adj_tap_2, adj_tap_3, adj_tap_4, input ready);
  modport sink(input valid, mode, cur_tap_0, cur_tap_1, cur_tap_2, cur_tap_3, cur_tap_4,
               adj_tap_0, adj_tap_1, adj_tap_2, adj_tap_3, adj_tap_4, output ready);
endinterface

interface tfdp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;

  modport source(output valid, pixel_out, input ready);
  modport sink(input valid, pixel_out, output ready);
endinterface
`default_nettype wire

// ===== sv/tfdp_front.sv =====
// Front end: accepts items, forms per-tap products, then the item's weighted sum.
`default_nettype none
module tfdp_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           filter_type,
  tfdp_in_if.sink             in_ch,
  input  wire tfdp_pkg::q_stat_t q_stat,
  output logic                push,
  output tfdp_pkg::q_entry_t  push_entry
);

  logic [tfdp_pkg::SAMPLE_W-1:0] cur [tfdp_pkg::TAPS];
  logic [tfdp_pkg::SAMPLE_W-1:0] adj [tfdp_pkg::TAPS];
  logic signed [tfdp_pkg::PAIR_W:0] op_s [tfdp_pkg::TAPS];
  tfdp_pkg::coef_t coef [tfdp_pkg::TAPS];
  tfdp_pkg::acc_t  prod_nxt [tfdp_pkg::TAPS];
  tfdp_pkg::acc_t  prod_r [tfdp_pkg::TAPS];
  tfdp_pkg::acc_t  sum_nxt;
  logic            s1_v_r, s1_mode_r;
  logic            s2_v_r;
  tfdp_pkg::q_entry_t s2_entry_r;
  logic            s1_ready, s2_ready;

  assign cur[0] = in_ch.cur_tap_0;
  assign cur[1] = in_ch.cur_tap_1;
  assign cur[2] = in_ch.cur_tap_2;
  assign cur[3] = in_ch.cur_tap_3;
  assign cur[4] = in_ch.cur_tap_4;
  assign adj[0] = in_ch.adj_tap_0;
  assign adj[1] = in_ch.adj_tap_1;
  assign adj[2] = in_ch.adj_tap_2;
  assign adj[3] = in_ch.adj_tap_3;
  assign adj[4] = in_ch.adj_tap_4;

  // high items filter cur+adj, low items cur alone
  always_comb begin
    for (int i = 0; i < tfdp_pkg::TAPS; i++) begin
      if (in_ch.mode) begin
        op_s[i] = signed'({1'b0, {1'b0, cur[i]} + {1'b0, adj[i]}});
        coef[i] = tfdp_pkg::HF_COEF[filter_type][i];
      end else begin
        op_s[i] = signed'({2'b00, cur[i]});
        coef[i] = tfdp_pkg::LF_COEF[filter_type][i];
      end
      prod_nxt[i] = op_s[i] * coef[i];
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < tfdp_pkg::TAPS; i++) begin
      sum_nxt = sum_nxt + prod_r[i];
    end
  end

  assign s2_ready    = !s2_v_r || !q_stat.full;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign push        = s2_v_r && !q_stat.full;
  assign push_entry  = s2_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_ch.valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      prod_r    <= prod_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_entry_r.mode <= s1_mode_r;
      s2_entry_r.sum  <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tfdp_queue.sv =====
// Short FIFO between the front end and the accumulate/output back end.
`default_nettype none
module tfdp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tfdp_pkg::q_entry_t push_entry,
  input  wire logic           pop,
  output tfdp_pkg::q_entry_t  head,
  output tfdp_pkg::q_stat_t   q_stat
);

  tfdp_pkg::q_entry_t mem [tfdp_pkg::QDEPTH];
  logic [tfdp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tfdp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (cnt_r == tfdp_pkg::QCNT_W'(tfdp_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

// ===== sv/tfdp_back.sv =====
// Back end: accumulator update, clamp to sample depth, registered pixel output.
`default_nettype none
module tfdp_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tfdp_pkg::DEPTH_W-1:0]  sample_depth,
  input  wire tfdp_pkg::q_entry_t            head,
  input  wire tfdp_pkg::q_stat_t             q_stat,
  output logic                               pop,
  tfdp_out_if.source                         out_ch
);

  tfdp_pkg::acc_t acc_r, acc_nxt;
  logic           out_v_r;
  logic [tfdp_pkg::SAMPLE_W-1:0] pix_r, pix_nxt;
  logic [tfdp_pkg::DEPTH_W-1:0]  depth;
  logic [tfdp_pkg::SAMPLE_W-1:0] mask;
  logic [tfdp_pkg::ACC_W-tfdp_pkg::SCALE_SH-1:0] hi;
  logic           out_free;

  assign out_free = !out_v_r || out_ch.ready;
  assign pop      = !q_stat.empty && (!head.mode || out_free);

  always_comb begin
    priority if (sample_depth < tfdp_pkg::DEPTH_W'(tfdp_pkg::DEPTH_MIN))
      depth = tfdp_pkg::DEPTH_W'(tfdp_pkg::DEPTH_MIN);
    else if (sample_depth > tfdp_pkg::DEPTH_W'(tfdp_pkg::SAMPLE_W))
      depth = tfdp_pkg::DEPTH_W'(tfdp_pkg::SAMPLE_W);
    else
      depth = sample_depth;
  end

  assign mask = {tfdp_pkg::SAMPLE_W{1'b1}} >> (tfdp_pkg::DEPTH_W'(tfdp_pkg::SAMPLE_W) - depth);

  always_comb begin
    acc_nxt = head.mode ? acc_r + head.sum : head.sum;
    hi      = acc_nxt[tfdp_pkg::ACC_W-1:tfdp_pkg::SCALE_SH];
    priority if (acc_nxt < 0)
      pix_nxt = '0;
    else if (hi > {{(tfdp_pkg::ACC_W-tfdp_pkg::SCALE_SH-tfdp_pkg::SAMPLE_W){1'b0}}, mask})
      pix_nxt = mask;
    else
      pix_nxt = hi[tfdp_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) acc_r <= acc_nxt;
      if (pop && head.mode) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.mode) pix_r <= pix_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.pixel_out = pix_r;

endmodule
`default_nettype wire

// ===== sv/three_field_deinterlace_pixel_top.sv =====
// Top level: config registers, front end, queue and back end of the pixel interpolator.
// A high item's products and sum are registered in turn, queued, and its pixel registered.
// Throughput: one item per cycle unless the output stalls, set by the single accumulator add.
// A stalled output fills the 4-entry queue, then the front stages, before input backs up.
// Reset (rst_n low, synchronous): accumulator 0, filter_type 1, sample_depth 8, all stages empty.
`default_nettype none
module three_field_deinterlace_pixel_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  tfdp_in_if.sink                               in_ch,
  tfdp_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [tfdp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tfdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                           filter_type_r;
  logic [tfdp_pkg::DEPTH_W-1:0]   sample_depth_r;
  logic                           push, pop;
  tfdp_pkg::q_entry_t             push_entry, head;
  tfdp_pkg::q_stat_t              q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_type_r  <= tfdp_pkg::FILTER_TYPE_RST;
      sample_depth_r <= tfdp_pkg::SAMPLE_DEPTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfdp_pkg::CFG_FILTER_TYPE:  filter_type_r  <= cfg_data[0];
        tfdp_pkg::CFG_SAMPLE_DEPTH: sample_depth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tfdp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .filter_type(filter_type_r),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  tfdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  tfdp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_depth(sample_depth_r),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue pop while empty");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && q_stat.empty) else $error("not idle after reset");

  a_low_silent: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head.mode && !out_ch.ready && out_ch.valid |=> out_ch.valid && $stable(out_ch.pixel_out))
    else $error("low item disturbed pending pixel");
`endif

endmodule
`default_nettype wire
